// ===== rtl/flme_pkg.sv =====
// ---------------------------------------------------------------------------
// flme_pkg
// Shared types and constants for the fuel level median/EMA filter.
// ---------------------------------------------------------------------------
package flme_pkg;

	localparam int FRACTION_WIDTH = 4;
	localparam int SAMPLE_W       = 8;
	localparam int AVG_W          = SAMPLE_W + FRACTION_WIDTH;
	localparam int ADC_W          = 10;
	localparam int SHIFT_W        = 3;
	localparam int LEVEL_W        = 5;
	localparam int WINDOW         = 9;
	localparam int SLOT_W         = 4;
	localparam int CNT_W          = 4;
	localparam int MEDIAN_RANK    = WINDOW / 2;
	localparam int THRESH_COUNT   = 26;

	localparam logic [SAMPLE_W-1:0] CLAMP_MAX     = 8'd254;
	localparam logic [LEVEL_W-1:0]  TOP_LITRES    = 5'd25;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET   = 3'd3;

	localparam logic [SAMPLE_W-1:0] LEVEL_BOUNDS [THRESH_COUNT] = '{
		8'd17,  8'd33,  8'd48,  8'd66,  8'd73,  8'd74,  8'd76,  8'd78,  8'd82,
		8'd85,  8'd89,  8'd103, 8'd113, 8'd120, 8'd136, 8'd162, 8'd170,
		8'd177, 8'd182, 8'd186, 8'd190, 8'd194, 8'd199, 8'd203, 8'd208, 8'd254
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STEP,
		ST_EMIT
	} flme_state_t;

	typedef struct packed {
		logic fill;
		logic write;
		logic scan;
		logic step;
	} flme_ctrl_t;

	typedef struct packed {
		logic                found;
		logic [SAMPLE_W-1:0] value;
	} flme_med_t;

endpackage

// ===== rtl/fuel_level_median_ema_filter.sv =====
// ---------------------------------------------------------------------------
// fuel_level_median_ema_filter
// Median-of-nine then moving-average filter for a fuel sender reading.
// ---------------------------------------------------------------------------
// Input stream: one ADC reading per beat on s_axis_tdata[9:0]. Readings
// above 254 are clamped. Output stream: one beat per input beat, carrying
// the litre level and the rounded filtered reading.
// The first reading after reset seeds the window and the average; its result
// goes straight to the emit state and the output register. Later readings
// run a median search over the window, one candidate per cycle on a shared
// compare row, then a step state updates the average and the emit state
// loads the output register; the block takes the next beat once back in
// idle. s_axis_tready is high only while the sequencer is idle; it stays
// high while a finished result waits in the output register.
// If the receiver stalls, the result holds in the output register and a
// second finished item waits in the sequencer until the register drains.
// smoothing_shift is written through cfg_valid/cfg_data and is always ready.
// Reset clears the window-primed flag, the average, the oldest-slot pointer
// and sets smoothing_shift to 3.
// ---------------------------------------------------------------------------
module fuel_level_median_ema_filter
	import flme_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] adc_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [4:0] level_litres, [12:5] smoothed_reading
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data        // [2:0] smoothing_shift
);

	flme_state_t         state_q;
	flme_state_t         state_d;
	flme_ctrl_t          ctrl;
	flme_med_t           med;
	logic                primed_q;
	logic [SHIFT_W-1:0]  smoothing_shift_q;
	logic [SAMPLE_W-1:0] sample;
	logic [SAMPLE_W-1:0] smoothed;
	logic [LEVEL_W-1:0]  litres;
	logic                in_beat;
	logic                out_load;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign sample        = (s_axis_tdata[ADC_W-1:0] > {2'b00, CLAMP_MAX}) ?
		CLAMP_MAX : s_axis_tdata[SAMPLE_W-1:0];

	always_comb begin
		state_d    = state_q;
		ctrl       = '0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					ctrl.fill  = !primed_q;
					ctrl.write = primed_q;
					state_d    = primed_q ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				ctrl.scan = !med.found;
				if (med.found) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				ctrl.step = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			primed_q          <= 1'b0;
			smoothing_shift_q <= SHIFT_RESET;
			m_axis_tvalid     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.fill) begin
				primed_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				smoothing_shift_q <= cfg_data;
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {3'b000, smoothed, litres};
		end
	end

	flme_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.sample (sample),
		.med    (med)
	);

	flme_ema u_ema (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.sample          (sample),
		.median          (med.value),
		.smoothing_shift (smoothing_shift_q),
		.smoothed        (smoothed),
		.litres          (litres)
	);

endmodule

// ===== rtl/flme_median.sv =====
// ---------------------------------------------------------------------------
// flme_median
// Nine-entry sample window with a rank-count median search, one candidate
// per cycle through a shared compare row.
// ---------------------------------------------------------------------------
module flme_median
	import flme_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  flme_ctrl_t          ctrl,
	input  logic [SAMPLE_W-1:0] sample,
	output flme_med_t           med
);

	logic [SAMPLE_W-1:0] window_q [WINDOW];
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   cand_q;
	logic                med_found_q;
	logic [SAMPLE_W-1:0] med_value_q;
	logic [SAMPLE_W-1:0] cand_val;
	logic [WINDOW-1:0]   lt_vec;
	logic [WINDOW-1:0]   le_vec;
	logic [CNT_W-1:0]    lt_cnt;
	logic [CNT_W-1:0]    le_cnt;
	logic                hit;

	assign cand_val = window_q[cand_q];
	assign med      = '{found: med_found_q, value: med_value_q};

	always_comb begin
		for (int j = 0; j < WINDOW; j++) begin
			lt_vec[j] = window_q[j] <  cand_val;
			le_vec[j] = window_q[j] <= cand_val;
		end
		lt_cnt = CNT_W'($countones(lt_vec));
		le_cnt = CNT_W'($countones(le_vec));
		hit    = (lt_cnt <= CNT_W'(MEDIAN_RANK)) && (le_cnt > CNT_W'(MEDIAN_RANK));
	end

	always_ff @(posedge clk) begin
		if (ctrl.fill) begin
			for (int j = 0; j < WINDOW; j++) begin
				window_q[j] <= sample;
			end
		end else if (ctrl.write) begin
			window_q[slot_q] <= sample;
		end
		if (ctrl.scan && hit) begin
			med_value_q <= cand_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			cand_q      <= '0;
			med_found_q <= 1'b0;
		end else begin
			if (ctrl.write) begin
				slot_q      <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
				cand_q      <= '0;
				med_found_q <= 1'b0;
			end else if (ctrl.scan) begin
				cand_q      <= cand_q + SLOT_W'(1);
				med_found_q <= hit;
			end else begin
				med_found_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/flme_ema.sv =====
// ---------------------------------------------------------------------------
// flme_ema
// Fixed-point moving average toward the median, rounding and litre lookup.
// ---------------------------------------------------------------------------
module flme_ema
	import flme_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  flme_ctrl_t          ctrl,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [SAMPLE_W-1:0] median,
	input  logic [SHIFT_W-1:0]  smoothing_shift,
	output logic [SAMPLE_W-1:0] smoothed,
	output logic [LEVEL_W-1:0]  litres
);

	logic [AVG_W-1:0]        avg_q;
	logic [AVG_W-1:0]        target;
	logic                    up;
	logic [AVG_W-1:0]        mag;
	logic [AVG_W-1:0]        move;
	logic [AVG_W:0]          round_sum;
	logic [AVG_W-FRACTION_WIDTH:0] rounded;
	logic [THRESH_COUNT-1:0] above;
	logic [LEVEL_W-1:0]      above_cnt;

	assign target = {median, FRACTION_WIDTH'(0)};
	assign up     = target >= avg_q;
	assign mag    = up ? (target - avg_q) : (avg_q - target);
	assign move   = mag >> smoothing_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
		end else if (ctrl.fill) begin
			avg_q <= {sample, FRACTION_WIDTH'(0)};
		end else if (ctrl.step) begin
			avg_q <= up ? (avg_q + move) : (avg_q - move);
		end
	end

	always_comb begin
		round_sum = {1'b0, avg_q} + (AVG_W + 1)'(1 << (FRACTION_WIDTH - 1));
		rounded   = round_sum[AVG_W:FRACTION_WIDTH];
		smoothed  = (rounded > {1'b0, CLAMP_MAX}) ? CLAMP_MAX : rounded[SAMPLE_W-1:0];
		for (int i = 0; i < THRESH_COUNT; i++) begin
			above[i] = smoothed > LEVEL_BOUNDS[i];
		end
		above_cnt = LEVEL_W'($countones(above));
		litres    = TOP_LITRES - above_cnt;
	end

endmodule

// ===== rtl/flme_checker.sv =====
// ---------------------------------------------------------------------------
// flme_checker
// Port-level checks for the fuel level filter, bound to the top level.
// ---------------------------------------------------------------------------
module flme_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while sequencer busy");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:0] <= 5'd25)
		else $error("litre level out of range");

	a_reading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[12:5] != 8'hFF && m_axis_tdata[15:13] == 3'b000)
		else $error("smoothed reading out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat dropped or changed under stall");

endmodule

bind fuel_level_median_ema_filter flme_checker u_flme_checker (.*);
